[hw/rtl/crsf_pkg.sv]
// constants and crc helper shared by the rc channels framer
package crsf_pkg;

  // frame header and crc
  localparam logic [7:0] SyncReset = 8'hC8;
  localparam logic [7:0] FrameLen  = 8'd24;
  localparam logic [7:0] FrameType = 8'h16;
  localparam logic [7:0] CrcPoly   = 8'hD5;

  // channel scaling
  localparam logic [11:0] UsMid    = 12'd1500;
  localparam logic [10:0] ChMid    = 11'd992;
  localparam logic [10:0] ChMin    = 11'd172;
  localparam logic [10:0] ChMax    = 11'd1811;
  // 2^18 / 5 rounded up, exact for dividends below 2^18
  localparam logic [15:0] DivRecip = 16'd52429;

  // channel position in the frame
  localparam logic [3:0] LastChan = 4'd15;

  // one byte through the crc-8, msb first, no reflection
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/crsf_chan_conv.sv]
// pulse width in microseconds to clamped 11-bit channel value
module crsf_chan_conv (
  input  logic [11:0] pulse_us,
  output logic [10:0] chan_value
);
  import crsf_pkg::*;

  logic               below;
  logic [11:0]        mag;
  logic [14:0]        scaled;
  logic [30:0]        prod;
  logic [12:0]        quot;
  logic signed [14:0] val;

  // magnitude of the offset from centre, times eight
  always_comb begin
    below  = pulse_us < UsMid;
    mag    = below ? (UsMid - pulse_us) : (pulse_us - UsMid);
    scaled = {mag, 3'b000};
  end

  // divide by five through the reciprocal, truncating the magnitude
  assign prod = {16'b0, scaled} * {15'b0, DivRecip};
  assign quot = prod[30:18];

  // apply sign around the centre and clamp
  always_comb begin
    if (below) begin
      val = $signed({4'b0, ChMid}) - $signed({2'b0, quot});
    end else begin
      val = $signed({4'b0, ChMid}) + $signed({2'b0, quot});
    end
    if (val < $signed({4'b0, ChMin})) begin
      chan_value = ChMin;
    end else if (val > $signed({4'b0, ChMax})) begin
      chan_value = ChMax;
    end else begin
      chan_value = val[10:0];
    end
  end

endmodule

[hw/rtl/crsf_rc_channels_framer_unit.sv]
// rc channels frame builder: converts, packs and crcs sixteen channels into a 26-byte frame
// Each request on the input carries one channel pulse width; sixteen of them make one frame
// of 26 bytes (sync, length 24, type 0x16, 22 payload bytes, crc-8 over type and payload),
// sent one byte per cycle while requests keep up and the receiver is ready, with tlast on
// the crc byte. The pulse width is converted and registered on acceptance; the next stage
// packs it, updates the crc and loads a four-byte output buffer that drains at one byte per
// cycle while the receiver is ready. The first channel releases 4 bytes (header plus one
// byte), the last 3 (two bytes plus crc) and the others 1 or 2. A new request is taken while
// the buffer still drains; its first byte reaches the output through the input register and
// the output buffer. The sync byte register is sampled when a frame's first channel loads.
module crsf_rc_channels_framer_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // frame_sync
  // channel requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [11:0] pulse_us, [15:12] zero
  // frame bytes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic        m_axis_tlast   // frame_end
);
  import crsf_pkg::*;

  logic [7:0]       frame_sync;
  logic [10:0]      conv_value;
  logic [10:0]      chan_r;
  logic             in_full;
  logic             in_accept;
  logic             load;
  logic             buf_free;
  logic [3:0][7:0]  buf_bytes;
  logic [2:0]       buf_count;
  logic             buf_end;

  logic [3:0]       chan_index;
  logic [6:0]       bit_residue;
  logic [2:0]       residue_count;
  logic [7:0]       running_crc;

  logic             first_chan;
  logic             last_chan;
  logic [2:0]       cnt;
  logic [6:0]       res;
  logic [6:0]       res_mask;
  logic [17:0]      acc;
  logic [4:0]       total;
  logic             two_bytes;
  logic [7:0]       b0;
  logic [7:0]       b1;
  logic [6:0]       bit_residue_next;
  logic [7:0]       crc_base;
  logic [7:0]       crc1;
  logic [7:0]       crc2;
  logic [7:0]       crc_new;
  logic [3:0][7:0]  load_bytes;
  logic [2:0]       load_count;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sync <= SyncReset;
    end else if (cfg_we) begin
      frame_sync <= cfg_wdata;
    end
  end

  // pulse conversion ahead of the input register
  crsf_chan_conv u_conv (
    .pulse_us   (s_axis_tdata[11:0]),
    .chan_value (conv_value)
  );

  // handshake between input register and output buffer
  assign buf_free      = (buf_count == 3'd0) || ((buf_count == 3'd1) && m_axis_tready);
  assign load          = in_full && buf_free;
  assign s_axis_tready = !in_full || load;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_accept || (in_full && !load);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      chan_r <= conv_value;
    end
  end

  // bit packing and crc for the waiting channel
  always_comb begin
    first_chan       = chan_index == 4'd0;
    last_chan        = chan_index == LastChan;
    cnt              = first_chan ? 3'd0 : residue_count;
    res_mask         = 7'((8'd1 << cnt) - 8'd1);
    res              = first_chan ? 7'd0 : (bit_residue & res_mask);
    acc              = ({7'b0, chan_r} << cnt) | {11'b0, res};
    total            = {2'b0, cnt} + 5'd11;
    two_bytes        = total[4];
    b0               = acc[7:0];
    b1               = acc[15:8];
    bit_residue_next = two_bytes ? {5'b0, acc[17:16]} : acc[14:8];
    crc_base         = first_chan ? crc_feed(8'h00, FrameType) : running_crc;
    crc1             = crc_feed(crc_base, b0);
    crc2             = crc_feed(crc1, b1);
    crc_new          = two_bytes ? crc2 : crc1;
  end

  // bytes released by this channel, first to leave in the lowest slot
  always_comb begin
    if (first_chan) begin
      load_bytes = {b0, FrameType, FrameLen, frame_sync};
      load_count = 3'd4;
    end else if (last_chan) begin
      if (two_bytes) begin
        load_bytes = {8'h00, crc_new, b1, b0};
        load_count = 3'd3;
      end else begin
        load_bytes = {8'h00, 8'h00, crc_new, b0};
        load_count = 3'd2;
      end
    end else begin
      if (two_bytes) begin
        load_bytes = {8'h00, 8'h00, b1, b0};
        load_count = 3'd2;
      end else begin
        load_bytes = {8'h00, 8'h00, 8'h00, b0};
        load_count = 3'd1;
      end
    end
  end

  // frame position state
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_index    <= 4'd0;
      bit_residue   <= 7'd0;
      residue_count <= 3'd0;
      running_crc   <= 8'h00;
    end else if (load) begin
      if (last_chan) begin
        chan_index    <= 4'd0;
        bit_residue   <= 7'd0;
        residue_count <= 3'd0;
        running_crc   <= 8'h00;
      end else begin
        chan_index    <= chan_index + 4'd1;
        bit_residue   <= bit_residue_next;
        residue_count <= total[2:0];
        running_crc   <= crc_new;
      end
    end
  end

  // output buffer, shifts one byte out per accepted output byte
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= 3'd0;
      buf_end   <= 1'b0;
    end else if (load) begin
      buf_count <= load_count;
      buf_end   <= last_chan;
    end else if (m_axis_tvalid && m_axis_tready) begin
      buf_count <= buf_count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_bytes <= load_bytes;
    end else if (m_axis_tvalid && m_axis_tready) begin
      buf_bytes <= {8'h00, buf_bytes[3:1]};
    end
  end

  assign m_axis_tvalid = buf_count != 3'd0;
  assign m_axis_tdata  = buf_bytes[0];
  assign m_axis_tlast  = buf_end && (buf_count == 3'd1);

  // buffer never holds more than one channel's bytes
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    buf_count <= 3'd4)
    else $error("output buffer count out of range");

  // only the first channel of a frame releases four bytes
  a_first_four: assert property (@(posedge clk) disable iff (rst)
    load |-> ((load_count == 3'd4) == (chan_index == 4'd0)))
    else $error("four-byte load outside the first channel");

  // the crc byte is only shown once the frame state has restarted
  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    m_axis_tlast |-> (m_axis_tvalid && chan_index == 4'd0))
    else $error("crc byte without frame restart");

  // the last channel leaves a clean residue and crc for the next frame
  a_last_clear: assert property (@(posedge clk) disable iff (rst)
    (load && last_chan) |=> (residue_count == 3'd0 && running_crc == 8'h00 && buf_end))
    else $error("frame state not cleared after last channel");

  // a load always replaces an empty or emptying buffer
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (buf_count == 3'd0 || (buf_count == 3'd1 && m_axis_tready)))
    else $error("buffer overwritten with bytes pending");

endmodule

[dv/tb.sv]
// self-checking testbench for the rc channels frame builder
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crsf_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainPause = 8;
  localparam int FramesRandom = 6;

  // one frame byte as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // one directed row: pulse width, optionally with its bytes typed in (first in [7:0])
  typedef struct packed {
    logic [11:0] pulse;
    logic [2:0]  typed_n;
    logic [31:0] typed_bytes;
  } pulse_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  // predictor state
  logic [7:0]  sync_reg = SyncReset;
  logic [3:0]  chan_pos = 4'd0;
  logic [6:0]  spill_bits = 7'd0;
  logic [2:0]  spill_len = 3'd0;
  logic [7:0]  frame_crc = 8'd0;

  frame_byte_t pending_bytes[$];
  int          errors = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;
  pulse_row_t  directed_rows [16];

  crsf_rc_channels_framer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // crc-8 over one byte, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // microseconds to clamped 11-bit channel value, division truncating toward zero
  function automatic logic [10:0] pulse_to_chan(input logic [11:0] us);
    int v;
    v = int'(ChMid) + (8 * (int'(us) - int'(UsMid))) / 5;
    if (v < int'(ChMin)) v = int'(ChMin);
    if (v > int'(ChMax)) v = int'(ChMax);
    return v[10:0];
  endfunction

  // work out the bytes one channel releases and queue them
  task automatic predict_pulse(input logic [11:0] us);
    logic [31:0] acc;
    int          cnt;
    if (chan_pos == 4'd0) begin
      pending_bytes.push_back('{sync_reg, 1'b0});
      pending_bytes.push_back('{FrameLen, 1'b0});
      pending_bytes.push_back('{FrameType, 1'b0});
      frame_crc = crc8_byte(8'd0, FrameType);
      spill_bits = 7'd0;
      spill_len = 3'd0;
    end
    cnt = int'(spill_len);
    acc = 32'(spill_bits) | (32'(pulse_to_chan(us)) << cnt);
    cnt += 11;
    while (cnt >= 8) begin
      pending_bytes.push_back('{acc[7:0], 1'b0});
      frame_crc = crc8_byte(frame_crc, acc[7:0]);
      acc = acc >> 8;
      cnt -= 8;
    end
    spill_bits = acc[6:0];
    spill_len = cnt[2:0];
    if (chan_pos == LastChan) begin
      pending_bytes.push_back('{frame_crc, 1'b1});
      chan_pos = 4'd0;
      spill_bits = 7'd0;
      spill_len = 3'd0;
      frame_crc = 8'd0;
    end else begin
      chan_pos = chan_pos + 4'd1;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %0s: got 0x%0h want 0x%0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // offer one channel request, with random gaps in front of it
  task automatic send_pulse(input logic [11:0] us, input pulse_row_t row, input bit typed);
    int base;
    while (idle_on && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, us};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    base = pending_bytes.size();
    predict_pulse(us);
    if (typed) begin
      // bytes typed into the table take the place of the predicted ones
      while (pending_bytes.size() > base) void'(pending_bytes.pop_back());
      for (int i = 0; i < int'(row.typed_n); i++) begin
        pending_bytes.push_back('{row.typed_bytes[8*i +: 8], 1'b0});
      end
    end
  endtask

  // wait until every expected byte is out, then let the pipeline settle
  task automatic drain_frames();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DrainPause) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sync_reg = value;
  endtask

  // random width: mostly nominal, some near the clamps, some anywhere
  function automatic logic [11:0] random_pulse();
    case ($urandom_range(9))
      0, 1:    return 12'($urandom_range(4095));
      2:       return 12'($urandom_range(995, 980));
      3:       return 12'($urandom_range(2020, 2005));
      default: return 12'($urandom_range(2012, 988));
    endcase
  endfunction

  // frame byte checker and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch("unexpected byte", m_axis_tdata, 0);
        end else begin
          frame_byte_t want;
          want = pending_bytes.pop_front();
          if (m_axis_tdata !== want.data) report_mismatch("out_byte", m_axis_tdata, want.data);
          if (m_axis_tlast !== want.last) report_mismatch("frame_end", m_axis_tlast, want.last);
        end
      end
      m_axis_tready <= !(idle_on && $urandom_range(99) < 7);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("crsf_rc_channels_framer_unit regression: fail");
      $finish;
    end
  end

  initial begin
    logic [7:0] phase_sync [FramesRandom];
    pulse_row_t none_row;
    none_row = '0;
    // first row after reset: zero clamps to 172, header plus its low byte
    directed_rows = '{
      '{12'd0,    3'd4, 32'hAC1618C8},
      '{12'd4095, 3'd0, 32'd0},
      '{12'd1500, 3'd0, 32'd0},
      '{12'd1499, 3'd0, 32'd0},
      '{12'd1501, 3'd0, 32'd0},
      '{12'd986,  3'd0, 32'd0},
      '{12'd987,  3'd0, 32'd0},
      '{12'd988,  3'd0, 32'd0},
      '{12'd2011, 3'd0, 32'd0},
      '{12'd2012, 3'd0, 32'd0},
      '{12'd2013, 3'd0, 32'd0},
      '{12'd1,    3'd0, 32'd0},
      '{12'd4094, 3'd0, 32'd0},
      '{12'h555,  3'd0, 32'd0},
      '{12'hAAA,  3'd0, 32'd0},
      '{12'h800,  3'd0, 32'd0}
    };
    phase_sync = '{8'hEE, 8'h00, 8'hFF, SyncReset, 8'($urandom_range(255)),
                   8'($urandom_range(255))};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frame with the reset sync byte
    foreach (directed_rows[i]) begin
      send_pulse(directed_rows[i].pulse, directed_rows[i], directed_rows[i].typed_n != 3'd0);
    end
    drain_frames();

    // random frames, one sync setting each, one of them with no stalls at all
    for (int p = 0; p < FramesRandom; p++) begin
      idle_on = (p != 1);
      write_sync(phase_sync[p]);
      for (int k = 0; k < 16; k++) begin
        send_pulse(random_pulse(), none_row, 1'b0);
      end
      drain_frames();
    end

    idle_on = 1'b1;
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("crsf_rc_channels_framer_unit regression: pass");
    end else begin
      $display("crsf_rc_channels_framer_unit regression: fail");
    end
    $finish;
  end

endmodule
